// File: hdl/texel_format_to_rgba8888_defines.svh
// Assertion helpers for the texel decoder.
// Both sample on the rising edge of clk and are idle while rst_n is low.
`ifndef TEXEL_FORMAT_TO_RGBA8888_DEFINES_SVH
`define TEXEL_FORMAT_TO_RGBA8888_DEFINES_SVH

// Condition and consequence in the same cycle
`define TFR_ASSERT_SAME(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("texel decoder: same-cycle check failed");

// Consequence in the cycle after the condition
`define TFR_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("texel decoder: next-cycle check failed");

`endif

// File: hdl/tfr_pkg.sv
`default_nettype none

package tfr_pkg;

    // Palette size
    localparam int PALETTE_DEPTH_DEFAULT = 256;

    // Configuration register indexes
    localparam logic [1:0] CFG_IMAGE_FORMAT    = 2'd0;
    localparam logic [1:0] CFG_TEXEL_SIZE      = 2'd1;
    localparam logic [1:0] CFG_PALETTE_ENABLED = 2'd2;

    // Image formats
    localparam logic [2:0] FMT_RGBA = 3'd0;
    localparam logic [2:0] FMT_IA   = 3'd1;
    localparam logic [2:0] FMT_I    = 3'd2;
    localparam logic [2:0] FMT_CI   = 3'd3;

    // Texel sizes
    localparam logic [1:0] SIZE_4  = 2'd0;
    localparam logic [1:0] SIZE_8  = 2'd1;
    localparam logic [1:0] SIZE_16 = 2'd2;
    localparam logic [1:0] SIZE_32 = 2'd3;

    // Transaction kinds
    localparam logic KIND_CONVERT = 1'b0;
    localparam logic KIND_PALETTE = 1'b1;

    // Masks
    localparam logic [4:0] MASK5   = 5'h1F;
    localparam logic [3:0] MASK_IA = 4'hE;
    localparam logic [3:0] MASK4   = 4'hF;
    localparam logic [7:0] OPAQUE  = 8'hFF;

    typedef struct packed {
        logic        kind;
        logic [31:0] raw_data;
        logic        odd_nibble;
        logic [7:0]  palette_index;
        logic [15:0] palette_value;
    } texel_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       unsupported;
    } rgba_t;

    // 5-bit channel to 8 bits by replication
    function automatic logic [7:0] widen5(input logic [4:0] v);
        logic [4:0] m;
        m = v & MASK5;
        return {m, m[4:2]};
    endfunction

    // 4-bit channel to 8 bits by replication
    function automatic logic [7:0] widen4(input logic [3:0] v);
        logic [3:0] m;
        m = v & MASK4;
        return {m, m};
    endfunction

    // RGBA5551 to 8-bit channels
    function automatic rgba_t rgba16(input logic [15:0] c);
        rgba_t r;
        r.red         = widen5(c[15:11]);
        r.green       = widen5(c[10:6]);
        r.blue        = widen5(c[5:1]);
        r.alpha       = c[0] ? OPAQUE : 8'h00;
        r.unsupported = 1'b0;
        return r;
    endfunction

    // Grey with separate alpha
    function automatic rgba_t grey(input logic [7:0] i, input logic [7:0] a);
        rgba_t r;
        r.red         = i;
        r.green       = i;
        r.blue        = i;
        r.alpha       = a;
        r.unsupported = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hdl/texel_format_to_rgba8888.sv
`default_nettype none
// Channel   Signals                              Direction  Moves
// texel     texel_valid, texel_stall, texel      in         convert or palette write
// rgba      rgba_valid, rgba_stall, rgba         out        one converted texel
// cfg       cfg_valid, cfg_ready, cfg_index/data in         register write
//
// One transaction accepted per clock while texel_stall is low; a converted texel passes
// the palette read register, then the result register, before it appears.
// Palette writes take effect at acceptance and give no result.
// rst_n clears the valid flags and the configuration registers; the palette is
// not cleared and must be written before it is read.
// texel_stall rises only when the stage register is full and the result is stalled.

`include "texel_format_to_rgba8888_defines.svh"

module texel_format_to_rgba8888 #(
    parameter int PALETTE_DEPTH = tfr_pkg::PALETTE_DEPTH_DEFAULT
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           texel_valid,
    output logic                texel_stall,
    input  wire tfr_pkg::texel_t texel,
    output logic                rgba_valid,
    input  wire logic           rgba_stall,
    output tfr_pkg::rgba_t      rgba,
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic [1:0]     cfg_index,
    input  wire logic [2:0]     cfg_data
);

    localparam int IDX_W = $clog2(PALETTE_DEPTH);

    // Configuration
    logic [2:0] image_format_reg;
    logic [1:0] texel_size_reg;
    logic       palette_enabled_reg;

    // Stage register
    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [31:0] s1_raw_reg;
    logic        s1_odd_reg;
    logic [15:0] pal_data_reg;

    // Result register
    logic           out_valid_reg;
    logic           out_valid_next;
    tfr_pkg::rgba_t out_reg;
    tfr_pkg::rgba_t out_next;

    logic       accept;
    logic       out_free;
    logic       s1_move;
    logic [3:0] in_nib;
    logic [7:0] lookup_sel;
    logic [IDX_W-1:0] rd_idx;
    logic [IDX_W-1:0] wr_idx;

    logic [15:0] palette_mem [PALETTE_DEPTH];

    // Index wrap table, built at elaboration
    logic [IDX_W-1:0] wrap_tbl [256];
    for (genvar g = 0; g < 256; g++)
    begin : g_wrap
        assign wrap_tbl[g] = IDX_W'(g % PALETTE_DEPTH);
    end

    // Handshake
    assign cfg_ready   = 1'b1;
    assign out_free    = !out_valid_reg || !rgba_stall;
    assign s1_move     = s1_valid_reg && out_free;
    assign texel_stall = s1_valid_reg && !out_free;
    assign accept      = texel_valid && !texel_stall;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_format_reg    <= tfr_pkg::FMT_RGBA;
            texel_size_reg      <= tfr_pkg::SIZE_16;
            palette_enabled_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == tfr_pkg::CFG_IMAGE_FORMAT)
                image_format_reg <= cfg_data;
            if (cfg_index == tfr_pkg::CFG_TEXEL_SIZE)
                texel_size_reg <= cfg_data[1:0];
            if (cfg_index == tfr_pkg::CFG_PALETTE_ENABLED)
                palette_enabled_reg <= cfg_data[0];
        end
    end

    // Palette addresses
    assign in_nib     = texel.odd_nibble ? texel.raw_data[3:0] : texel.raw_data[7:4];
    assign lookup_sel = (texel_size_reg == tfr_pkg::SIZE_4) ? {4'h0, in_nib}
                                                            : texel.raw_data[7:0];
    assign rd_idx     = wrap_tbl[lookup_sel];
    assign wr_idx     = wrap_tbl[texel.palette_index];

    // Palette memory: write on palette transactions, read on conversions
    always_ff @(posedge clk)
    begin
        if (accept && texel.kind == tfr_pkg::KIND_PALETTE)
            palette_mem[wr_idx] <= texel.palette_value;
        if (accept && texel.kind == tfr_pkg::KIND_CONVERT)
            pal_data_reg <= palette_mem[rd_idx];
    end

    // Stage register
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = (texel.kind == tfr_pkg::KIND_CONVERT);
        else if (s1_move)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept && texel.kind == tfr_pkg::KIND_CONVERT)
        begin
            s1_raw_reg <= texel.raw_data;
            s1_odd_reg <= texel.odd_nibble;
        end
    end

    // Format decode
    always_comb
    begin
        logic [3:0] nib;
        logic [7:0] byte_v;
        logic [15:0] half;
        logic [3:0] ia_i;
        logic ok;
        nib    = s1_odd_reg ? s1_raw_reg[3:0] : s1_raw_reg[7:4];
        byte_v = s1_raw_reg[7:0];
        half   = s1_raw_reg[15:0];
        ia_i   = nib & tfr_pkg::MASK_IA;
        ok     = 1'b1;
        out_next = '0;
        unique case (image_format_reg)
            tfr_pkg::FMT_RGBA:
            begin
                if (texel_size_reg == tfr_pkg::SIZE_16)
                    out_next = tfr_pkg::rgba16(half);
                else if (texel_size_reg == tfr_pkg::SIZE_32)
                begin
                    out_next.red   = s1_raw_reg[31:24];
                    out_next.green = s1_raw_reg[23:16];
                    out_next.blue  = s1_raw_reg[15:8];
                    out_next.alpha = s1_raw_reg[7:0];
                end
                else
                    ok = 1'b0;
            end
            tfr_pkg::FMT_IA:
            begin
                unique case (texel_size_reg)
                    tfr_pkg::SIZE_4:
                        out_next = tfr_pkg::grey({ia_i[3:1], ia_i[3:1], ia_i[3:2]},
                                                 nib[0] ? tfr_pkg::OPAQUE : 8'h00);
                    tfr_pkg::SIZE_8:
                        out_next = tfr_pkg::grey(tfr_pkg::widen4(byte_v[7:4]),
                                                 tfr_pkg::widen4(byte_v[3:0]));
                    tfr_pkg::SIZE_16:
                        out_next = tfr_pkg::grey(half[15:8], half[7:0]);
                    tfr_pkg::SIZE_32:
                        ok = 1'b0;
                endcase
            end
            tfr_pkg::FMT_I:
            begin
                if (texel_size_reg == tfr_pkg::SIZE_4)
                    out_next = tfr_pkg::grey(tfr_pkg::widen4(nib), tfr_pkg::widen4(nib));
                else if (texel_size_reg == tfr_pkg::SIZE_8)
                    out_next = tfr_pkg::grey(byte_v, byte_v);
                else
                    ok = 1'b0;
            end
            tfr_pkg::FMT_CI:
            begin
                if (palette_enabled_reg && (texel_size_reg == tfr_pkg::SIZE_4 ||
                                            texel_size_reg == tfr_pkg::SIZE_8))
                    out_next = tfr_pkg::rgba16(pal_data_reg);
                else
                    ok = 1'b0;
            end
            default:
                ok = 1'b0;
        endcase
        if (!ok)
        begin
            out_next = '0;
            out_next.unsupported = 1'b1;
        end
    end

    // Result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_move)
            out_valid_next = 1'b1;
        else if (!rgba_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
            out_reg <= out_next;
    end

    assign rgba_valid = out_valid_reg;
    assign rgba       = out_reg;

    // Checks
    `TFR_ASSERT_NEXT(a_pal_no_result, accept && texel.kind == tfr_pkg::KIND_PALETTE, !s1_valid_reg)
    `TFR_ASSERT_NEXT(a_conv_staged, accept && texel.kind == tfr_pkg::KIND_CONVERT, s1_valid_reg)
    `TFR_ASSERT_NEXT(a_stage_drains, s1_move, out_valid_reg)
    `TFR_ASSERT_SAME(a_err_zero, out_valid_reg && out_reg.unsupported,
                     out_reg.red == 8'h00 && out_reg.green == 8'h00 &&
                     out_reg.blue == 8'h00 && out_reg.alpha == 8'h00)

endmodule

`default_nettype wire
